FILE: sv/lstu_pkg.sv
// Shared types and codes for the load/store transfer unit.
// No dependencies; imported by arm_load_store_transfer_unit.
package lstu_pkg;

    localparam int unsigned WordW  = 32;
    localparam int unsigned InDataW  = 168;
    localparam int unsigned OutDataW = 112;

    // Request kinds carried on the input tuser.
    typedef enum logic [1:0] {
        REQ_WORD_BYTE = 2'd0,
        REQ_HALF      = 2'd1,
        REQ_LOAD_RET  = 2'd2,
        REQ_UNUSED    = 2'd3
    } req_type_t;

    // Kind of the load waiting for its data.
    typedef enum logic [2:0] {
        KIND_WORD  = 3'd0,
        KIND_BYTE  = 3'd1,
        KIND_UHALF = 3'd2,
        KIND_SBYTE = 3'd3,
        KIND_SHALF = 3'd4
    } load_kind_t;

    typedef enum logic [1:0] {
        SHIFT_LSL = 2'd0,
        SHIFT_LSR = 2'd1,
        SHIFT_ASR = 2'd2,
        SHIFT_ROR = 2'd3
    } shift_type_t;

    // Transfer size codes on the memory request.
    localparam logic [1:0] SizeByte = 2'd0;
    localparam logic [1:0] SizeHalf = 2'd1;
    localparam logic [1:0] SizeWord = 2'd2;

    // S:H sub-codes of the halfword forms.
    localparam logic [1:0] ShNone  = 2'b00;
    localparam logic [1:0] ShUHalf = 2'b01;
    localparam logic [1:0] ShSByte = 2'b10;
    localparam logic [1:0] ShSHalf = 2'b11;

    localparam logic [3:0] RegPc = 4'hF;

    typedef struct packed {
        logic              mem_valid;
        logic              mem_write;
        logic [WordW-1:0]  mem_addr;
        logic [1:0]        mem_size;
        logic [WordW-1:0]  write_data;
        logic              wb_en;
        logic [3:0]        wb_index;
        logic [WordW-1:0]  wb_value;
        logic              pc_reload;
        logic              unsupported;
    } result_t;

endpackage

FILE: sv/arm_load_store_transfer_unit.sv
// Top level of the ARMv4 single data transfer unit.
// Depends on lstu_pkg for the request codes, load kinds and result type.

// Takes one request per cycle on the input stream and returns exactly one result
// for each, in order, from the output register. An issue request decodes the
// offset (immediate, shifted or plain register, or split immediate),
// forms the pre- or post-indexed address and gives the memory request and any base
// write-back; a load issue leaves a pending record that the next load-return request
// uses to align or sign extend the returned word and write rd. The decode, the
// barrel shift and the 32-bit add sit between the input ports and the result
// register; a skid stage behind it keeps the input ready while one result stalls,
// so the throughput is one request per cycle as long as results are taken.
module arm_load_store_transfer_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // tdata, lowest bit up: instr[31:0], base_value[31:0], offset_reg_value[31:0],
    // store_value[31:0], carry_in, load_data[31:0], zero fill.
    input  logic [lstu_pkg::InDataW-1:0]  s_axis_tdata,
    // tuser: req_type[1:0].
    input  logic [1:0]                    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // tdata, lowest bit up: mem_valid, mem_write, mem_addr[31:0], mem_size[1:0],
    // write_data[31:0], wb_en, wb_index[3:0], wb_value[31:0], pc_reload,
    // unsupported, zero fill.
    output logic [lstu_pkg::OutDataW-1:0] m_axis_tdata
);
    import lstu_pkg::*;

    logic [WordW-1:0] instr, base_value, offset_reg_value, store_value, load_data;
    logic             carry_in;
    req_type_t        req_type;

    assign instr            = s_axis_tdata[31:0];
    assign base_value       = s_axis_tdata[63:32];
    assign offset_reg_value = s_axis_tdata[95:64];
    assign store_value      = s_axis_tdata[127:96];
    assign carry_in         = s_axis_tdata[128];
    assign load_data        = s_axis_tdata[160:129];
    assign req_type         = req_type_t'(s_axis_tuser);

    // Pending load record.
    logic       pending_valid_reg, pending_valid_next;
    load_kind_t pending_kind_reg, pending_kind_next;
    logic [1:0] pending_addr_low_reg, pending_addr_low_next;
    logic [3:0] pending_dest_reg, pending_dest_next;

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_reg, out_next;
    result_t skid_reg, skid_next;

    logic s_accept;
    assign s_axis_tready = !skid_valid_reg;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // ---------------- offset decode ----------------
    shift_type_t      shift_type;
    logic [4:0]       shift_amt;
    logic [WordW-1:0] shifted;
    logic [2*WordW-1:0] rot_pair;

    assign shift_type = shift_type_t'(instr[6:5]);
    assign shift_amt  = instr[11:7];
    assign rot_pair   = {offset_reg_value, offset_reg_value} >> shift_amt;

    always_comb begin
        unique case (shift_type)
            SHIFT_LSL: shifted = offset_reg_value << shift_amt;
            SHIFT_LSR: shifted = (shift_amt == 5'd0) ? '0 : (offset_reg_value >> shift_amt);
            SHIFT_ASR: begin
                // An amount of zero encodes a shift by 32: the sign fills the word.
                if (shift_amt == 5'd0) begin
                    shifted = {WordW{offset_reg_value[WordW-1]}};
                end else begin
                    shifted = WordW'($signed(offset_reg_value) >>> shift_amt);
                end
            end
            SHIFT_ROR: begin
                if (shift_amt == 5'd0) begin
                    shifted = {carry_in, offset_reg_value[WordW-1:1]};
                end else begin
                    shifted = rot_pair[WordW-1:0];
                end
            end
            default: shifted = offset_reg_value;
        endcase
    end

    logic             is_half, is_load, sh_bad;
    logic [1:0]       sh_code;
    logic [WordW-1:0] offset, addr, eff;

    assign is_half = (req_type == REQ_HALF);
    assign is_load = instr[20];
    assign sh_code = instr[6:5];
    assign sh_bad  = (sh_code == ShNone) || (!is_load && sh_code != ShUHalf);

    always_comb begin
        if (is_half) begin
            offset = instr[22] ? {24'd0, instr[11:8], instr[3:0]} : offset_reg_value;
        end else begin
            offset = instr[25] ? shifted : {20'd0, instr[11:0]};
        end
    end

    assign addr = instr[23] ? (base_value + offset) : (base_value - offset);
    assign eff  = instr[24] ? addr : base_value;

    // ---------------- load return alignment ----------------
    logic [7:0]       lane_byte;
    logic [15:0]      lane_half;
    logic [WordW-1:0] rot_word, ret_value;

    always_comb begin
        unique case (pending_addr_low_reg)
            2'd0: begin
                lane_byte = load_data[7:0];
                rot_word  = load_data;
            end
            2'd1: begin
                lane_byte = load_data[15:8];
                rot_word  = {load_data[7:0], load_data[31:8]};
            end
            2'd2: begin
                lane_byte = load_data[23:16];
                rot_word  = {load_data[15:0], load_data[31:16]};
            end
            default: begin
                lane_byte = load_data[31:24];
                rot_word  = {load_data[23:0], load_data[31:24]};
            end
        endcase
        lane_half = pending_addr_low_reg[1] ? load_data[31:16] : load_data[15:0];
    end

    always_comb begin
        unique case (pending_kind_reg)
            KIND_WORD:  ret_value = rot_word;
            KIND_BYTE:  ret_value = {24'd0, lane_byte};
            KIND_UHALF: begin
                // An odd address gives the halfword rotated right by one byte.
                ret_value = pending_addr_low_reg[0] ?
                            {lane_half[7:0], 16'd0, lane_half[15:8]} : {16'd0, lane_half};
            end
            KIND_SBYTE: ret_value = {{24{lane_byte[7]}}, lane_byte};
            default: begin
                ret_value = pending_addr_low_reg[0] ? {{24{lane_byte[7]}}, lane_byte}
                                                    : {{16{lane_half[15]}}, lane_half};
            end
        endcase
    end

    // ---------------- result and pending update ----------------
    result_t item_res;

    always_comb begin
        item_res              = '0;
        pending_valid_next    = pending_valid_reg;
        pending_kind_next     = pending_kind_reg;
        pending_addr_low_next = pending_addr_low_reg;
        pending_dest_next     = pending_dest_reg;

        unique case (req_type) inside
            REQ_WORD_BYTE, REQ_HALF: begin
                if (is_half && sh_bad) begin
                    item_res.unsupported = 1'b1;
                end else begin
                    item_res.mem_valid  = 1'b1;
                    item_res.mem_write  = !is_load;
                    item_res.mem_addr   = eff;
                    item_res.write_data = is_load ? '0 : store_value;
                    if (is_half) begin
                        item_res.mem_size = (sh_code == ShSByte) ? SizeByte : SizeHalf;
                    end else begin
                        item_res.mem_size = instr[22] ? SizeByte : SizeWord;
                    end
                    if (!instr[24] || instr[21]) begin
                        item_res.wb_en    = 1'b1;
                        item_res.wb_index = instr[19:16];
                        item_res.wb_value = addr;
                    end
                    if (is_load) begin
                        pending_valid_next    = 1'b1;
                        pending_addr_low_next = eff[1:0];
                        pending_dest_next     = instr[15:12];
                        if (is_half) begin
                            case (sh_code)
                                ShUHalf: pending_kind_next = KIND_UHALF;
                                ShSByte: pending_kind_next = KIND_SBYTE;
                                default: pending_kind_next = KIND_SHALF;
                            endcase
                        end else begin
                            pending_kind_next = instr[22] ? KIND_BYTE : KIND_WORD;
                        end
                    end
                end
            end
            REQ_LOAD_RET: begin
                if (pending_valid_reg) begin
                    item_res.wb_en     = 1'b1;
                    item_res.wb_index  = pending_dest_reg;
                    item_res.wb_value  = ret_value;
                    item_res.pc_reload = (pending_dest_reg == RegPc);
                    pending_valid_next = 1'b0;
                end
            end
            default: item_res = '0;
        endcase
    end

    // ---------------- output register and skid stage ----------------
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (m_axis_tready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = s_accept;
                out_next       = item_res;
            end
        end else if (s_accept) begin
            skid_valid_next = 1'b1;
            skid_next       = item_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg        <= 1'b0;
            skid_valid_reg       <= 1'b0;
            pending_valid_reg    <= 1'b0;
            pending_kind_reg     <= KIND_WORD;
            pending_addr_low_reg <= 2'd0;
            pending_dest_reg     <= 4'd0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
            if (s_accept) begin
                pending_valid_reg    <= pending_valid_next;
                pending_kind_reg     <= pending_kind_next;
                pending_addr_low_reg <= pending_addr_low_next;
                pending_dest_reg     <= pending_dest_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_reg.unsupported, out_reg.pc_reload, out_reg.wb_value,
                            out_reg.wb_index, out_reg.wb_en, out_reg.write_data,
                            out_reg.mem_size, out_reg.mem_addr, out_reg.mem_write,
                            out_reg.mem_valid};

    // ---------------- assertions ----------------
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds a result while the output register is empty");

    a_unsup_no_access: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.unsupported) |-> (!out_reg.mem_valid && !out_reg.wb_en))
        else $error("unsupported request produced an access or write-back");

    a_reload_pc: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.pc_reload) |-> (out_reg.wb_en && out_reg.wb_index == RegPc))
        else $error("pipeline reload without a write of the program counter");

    a_load_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && item_res.mem_valid && !item_res.mem_write) |=> pending_valid_reg)
        else $error("accepted load left no pending record");

endmodule
